>>> hdl/fold_posture_range_classifier_macros.svh
// ----------------------------------------------------------------------------
// Fold posture range classifier: assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FOLD_POSTURE_RANGE_CLASSIFIER_MACROS_SVH
`define FOLD_POSTURE_RANGE_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge outside reset.
`define FPRC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fprc assertion failed");

// When the first expression holds, the second must hold in the next cycle.
`define FPRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fprc assertion failed");

`else

`define FPRC_ASSERT(label, prop)
`define FPRC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hdl/fprc_pkg.sv
// ----------------------------------------------------------------------------
// fprc_pkg
// Shared widths, codes and controller/datapath interface types for the
// fold posture range classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fprc_pkg;

    localparam int CMD_W       = 2;
    localparam int AXIS_W      = 2;
    localparam int ENTRY_W     = 4;
    localparam int POS_W       = 19;
    localparam int POSTURE_W   = 3;
    localparam int AXES_CFG_W  = 3;
    localparam int COUNT_CFG_W = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [POS_W-1:0]     POS_MAX      = 19'd360000;
    localparam logic [POSTURE_W-1:0] POSTURE_NONE = 3'd0;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_AXES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_POSITION  = 2'd0,
        CMD_FORCE_POSTURE = 2'd1,
        CMD_LOAD_ENTRY    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXEC   = 2'd1,
        ST_SCAN   = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic scan;
        logic deliver;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

>>> hdl/fprc_ram.sv
// ----------------------------------------------------------------------------
// fprc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fprc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/fprc_ctrl.sv
// ----------------------------------------------------------------------------
// fprc_ctrl
// Command sequencer: takes one item, runs its immediate effects, drives the
// table scan when one is needed and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fprc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  fprc_pkg::dp_status_t   status,
    output fprc_pkg::ctrl_cmd_t    ctrl
);

    fprc_pkg::state_t state_reg;
    fprc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fprc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            fprc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = fprc_pkg::ST_EXEC;
                end
            end
            fprc_pkg::ST_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = status.need_scan ? fprc_pkg::ST_SCAN : fprc_pkg::ST_FINISH;
            end
            fprc_pkg::ST_SCAN:
            begin
                ctrl.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = fprc_pkg::ST_FINISH;
                end
            end
            fprc_pkg::ST_FINISH:
            begin
                // The result waits here while the output register is still full.
                if (status.out_free)
                begin
                    ctrl.deliver = 1'b1;
                    state_next   = fprc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fprc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/fprc_datapath.sv
// ----------------------------------------------------------------------------
// fprc_datapath
// Axis positions, posture table memories, configuration registers, the
// one-entry-per-cycle table scan and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fprc_datapath #(
    parameter int MAX_ENTRIES = 16,
    parameter int MAX_AXES    = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [fprc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fprc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [fprc_pkg::CMD_W-1:0]           command,
    input  logic [fprc_pkg::AXIS_W-1:0]          axis_number,
    input  logic [fprc_pkg::ENTRY_W-1:0]         entry_number,
    input  logic [fprc_pkg::POS_W-1:0]           new_position,
    input  logic [fprc_pkg::POS_W-1:0]           bound_low,
    input  logic [fprc_pkg::POS_W-1:0]           bound_high,
    input  logic [fprc_pkg::POSTURE_W-1:0]       posture_code,
    output logic [fprc_pkg::POSTURE_W-1:0]       posture,
    output logic                                 posture_changed,
    output logic                                 ignored,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    input  fprc_pkg::ctrl_cmd_t                  ctrl,
    output fprc_pkg::dp_status_t                 status
);

    localparam int POS_W = fprc_pkg::POS_W;
    localparam int PW    = fprc_pkg::POSTURE_W;
    localparam int BW    = 2 * POS_W;
    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int XW    = (AW > fprc_pkg::ENTRY_W) ? AW : fprc_pkg::ENTRY_W;
    localparam int NAW   = $clog2(MAX_AXES + 1);
    localparam int AXW   = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam int AXX   = (AXW > fprc_pkg::AXIS_W) ? AXW : fprc_pkg::AXIS_W;

    function automatic logic [POS_W-1:0] midpoint(input logic [POS_W-1:0] lo,
                                                  input logic [POS_W-1:0] hi);
        logic [POS_W:0]   sum;
        logic [POS_W-1:0] mid;
        sum = {1'b0, lo} + {1'b0, hi};
        mid = sum[POS_W:1];
        return (mid > fprc_pkg::POS_MAX) ? fprc_pkg::POS_MAX : mid;
    endfunction

    // Configuration registers.
    logic [fprc_pkg::AXES_CFG_W-1:0]  active_axes_reg, active_axes_next;
    logic [fprc_pkg::COUNT_CFG_W-1:0] entry_count_reg, entry_count_next;

    // Captured item.
    fprc_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [fprc_pkg::AXIS_W-1:0]      axis_reg, axis_next;
    logic [fprc_pkg::ENTRY_W-1:0]     entry_reg, entry_next;
    logic [POS_W-1:0]                 pos_reg, pos_next;
    logic [POS_W-1:0]                 lo_reg, lo_next;
    logic [POS_W-1:0]                 hi_reg, hi_next;
    logic [PW-1:0]                    code_reg, code_next;

    // Block state.
    logic [POS_W-1:0]                 axis_pos_reg [MAX_AXES];
    logic [POS_W-1:0]                 axis_pos_next [MAX_AXES];
    logic [PW-1:0]                    cur_posture_reg, cur_posture_next;
    logic                             res_changed_reg, res_changed_next;
    logic                             res_ignored_reg, res_ignored_next;

    // Scan pipeline.
    logic [CW-1:0]                    issue_idx_reg, issue_idx_next;
    logic                             pend_valid_reg, pend_valid_next;

    // Output register.
    logic                             out_valid_reg, out_valid_next;
    logic [PW-1:0]                    out_posture_reg, out_posture_next;
    logic                             out_changed_reg, out_changed_next;
    logic                             out_ignored_reg, out_ignored_next;

    logic [NAW-1:0]                   na;
    logic [CW-1:0]                    ne;
    logic [AXX-1:0]                   axis_ext;
    logic [AXW-1:0]                   axis_idx;
    logic [XW-1:0]                    entry_ext;
    logic [AW-1:0]                    waddr;
    logic [AW-1:0]                    raddr;
    logic                             set_ok;
    logic                             force_ok;
    logic                             load_ok;
    logic                             need_scan;
    logic                             imm_changed;
    logic                             imm_ignored;
    logic                             load_we;
    logic [MAX_AXES-1:0]              bound_we;
    logic [BW-1:0]                    bound_rd [MAX_AXES];
    logic [PW-1:0]                    rd_posture;
    logic                             is_classify;
    logic                             brk;
    logic                             hit;
    logic                             exhausted;
    logic                             scan_done;
    logic [PW-1:0]                    class_result;
    logic                             force_match;

    always_comb
    begin
        na = (32'(active_axes_reg) > MAX_AXES) ? NAW'(MAX_AXES) : NAW'(active_axes_reg);
        ne = (32'(entry_count_reg) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(entry_count_reg);
        axis_ext  = AXX'(axis_reg);
        axis_idx  = axis_ext[AXW-1:0];
        entry_ext = XW'(entry_reg);
        waddr     = entry_ext[AW-1:0];
        raddr     = issue_idx_reg[AW-1:0];
    end

    // Command decode on the captured item.
    always_comb
    begin
        set_ok   = (32'(axis_reg) < 32'(na)) && (axis_pos_reg[axis_idx] != pos_reg);
        force_ok = (code_reg != cur_posture_reg);
        load_ok  = (32'(axis_reg) < MAX_AXES) && (32'(entry_reg) < MAX_ENTRIES);
        need_scan   = 1'b0;
        imm_changed = 1'b0;
        imm_ignored = 1'b0;
        unique case (cmd_reg)
            fprc_pkg::CMD_SET_POSITION:
            begin
                need_scan   = set_ok;
                imm_ignored = !set_ok;
            end
            fprc_pkg::CMD_FORCE_POSTURE:
            begin
                need_scan   = force_ok;
                imm_changed = force_ok;
                imm_ignored = !force_ok;
            end
            fprc_pkg::CMD_LOAD_ENTRY:
            begin
                imm_ignored = !load_ok;
            end
            default:
            begin
                imm_ignored = 1'b1;
            end
        endcase
        load_we = ctrl.exec && (cmd_reg == fprc_pkg::CMD_LOAD_ENTRY) && load_ok;
    end

    // One memory per axis holds the low and high bounds of every entry, so a
    // load touches one axis and a scan reads every axis of one entry at once.
    for (genvar g = 0; g < MAX_AXES; g++)
    begin : g_axis_ram
        assign bound_we[g] = load_we && (axis_idx == AXW'(g));

        fprc_ram #(
            .WIDTH (BW),
            .DEPTH (MAX_ENTRIES)
        ) u_bound_ram (
            .clk   (clk),
            .we    (bound_we[g]),
            .waddr (waddr),
            .wdata ({lo_reg, hi_reg}),
            .raddr (raddr),
            .rdata (bound_rd[g])
        );
    end

    fprc_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_ENTRIES)
    ) u_posture_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (waddr),
        .wdata (code_reg),
        .raddr (raddr),
        .rdata (rd_posture)
    );

    // Check stage of the scan: the entry read in the previous cycle.
    always_comb
    begin
        is_classify = (cmd_reg == fprc_pkg::CMD_SET_POSITION);
        brk = bound_rd[0][BW-1:POS_W] > axis_pos_reg[0];
        hit = 1'b1;
        for (int a = 0; a < MAX_AXES; a++)
        begin
            if (a < int'(na))
            begin
                if ((bound_rd[a][BW-1:POS_W] > axis_pos_reg[a]) ||
                    (bound_rd[a][POS_W-1:0] < axis_pos_reg[a]))
                begin
                    hit = 1'b0;
                end
            end
        end
        exhausted    = (issue_idx_reg == ne);
        scan_done    = exhausted || (is_classify && pend_valid_reg && (brk || hit));
        class_result = (pend_valid_reg && !brk && hit) ? rd_posture : fprc_pkg::POSTURE_NONE;
        force_match  = ctrl.scan && !is_classify && pend_valid_reg && (rd_posture == code_reg);
    end

    always_comb
    begin
        active_axes_next = active_axes_reg;
        entry_count_next = entry_count_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                fprc_pkg::REG_ACTIVE_AXES: active_axes_next = cfg_data[fprc_pkg::AXES_CFG_W-1:0];
                fprc_pkg::REG_ENTRY_COUNT: entry_count_next = cfg_data[fprc_pkg::COUNT_CFG_W-1:0];
                default:                   active_axes_next = active_axes_reg;
            endcase
        end

        cmd_next   = cmd_reg;
        axis_next  = axis_reg;
        entry_next = entry_reg;
        pos_next   = pos_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        code_next  = code_reg;
        if (ctrl.capture)
        begin
            cmd_next   = fprc_pkg::cmd_t'(command);
            axis_next  = axis_number;
            entry_next = entry_number;
            pos_next   = (new_position > fprc_pkg::POS_MAX) ? fprc_pkg::POS_MAX : new_position;
            lo_next    = bound_low;
            hi_next    = bound_high;
            code_next  = posture_code;
        end

        axis_pos_next    = axis_pos_reg;
        cur_posture_next = cur_posture_reg;
        res_changed_next = res_changed_reg;
        res_ignored_next = res_ignored_reg;
        issue_idx_next   = issue_idx_reg;
        pend_valid_next  = pend_valid_reg;

        if (ctrl.exec)
        begin
            res_changed_next = imm_changed;
            res_ignored_next = imm_ignored;
            issue_idx_next   = '0;
            pend_valid_next  = 1'b0;
            if (is_classify && set_ok)
            begin
                axis_pos_next[axis_idx] = pos_reg;
            end
            if ((cmd_reg == fprc_pkg::CMD_FORCE_POSTURE) && force_ok)
            begin
                cur_posture_next = code_reg;
            end
        end

        if (ctrl.scan)
        begin
            if (!exhausted)
            begin
                issue_idx_next  = issue_idx_reg + CW'(1);
                pend_valid_next = 1'b1;
            end
            else
            begin
                pend_valid_next = 1'b0;
            end
            if (is_classify && scan_done)
            begin
                cur_posture_next = class_result;
                res_changed_next = (class_result != cur_posture_reg);
            end
        end

        // Every matching entry overwrites the axes, so the last match wins.
        if (force_match)
        begin
            for (int a = 0; a < MAX_AXES; a++)
            begin
                if (a < int'(na))
                begin
                    axis_pos_next[a] = midpoint(bound_rd[a][BW-1:POS_W],
                                                bound_rd[a][POS_W-1:0]);
                end
            end
        end

        out_valid_next   = out_valid_reg;
        out_posture_next = out_posture_reg;
        out_changed_next = out_changed_reg;
        out_ignored_next = out_ignored_reg;
        if (ctrl.deliver)
        begin
            out_valid_next   = 1'b1;
            out_posture_next = cur_posture_reg;
            out_changed_next = res_changed_reg;
            out_ignored_next = res_ignored_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_axes_reg <= '0;
            entry_count_reg <= '0;
            for (int a = 0; a < MAX_AXES; a++)
            begin
                axis_pos_reg[a] <= '0;
            end
            cur_posture_reg <= fprc_pkg::POSTURE_NONE;
            issue_idx_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            active_axes_reg <= active_axes_next;
            entry_count_reg <= entry_count_next;
            axis_pos_reg    <= axis_pos_next;
            cur_posture_reg <= cur_posture_next;
            issue_idx_reg   <= issue_idx_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        axis_reg        <= axis_next;
        entry_reg       <= entry_next;
        pos_reg         <= pos_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        code_reg        <= code_next;
        res_changed_reg <= res_changed_next;
        res_ignored_reg <= res_ignored_next;
        out_posture_reg <= out_posture_next;
        out_changed_reg <= out_changed_next;
        out_ignored_reg <= out_ignored_next;
    end

    assign status.need_scan = need_scan;
    assign status.scan_done = scan_done;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign posture         = out_posture_reg;
    assign posture_changed = out_changed_reg;
    assign ignored         = out_ignored_reg;

endmodule

>>> hdl/fold_posture_range_classifier.sv
// ----------------------------------------------------------------------------
// fold_posture_range_classifier
// Tracks hinge and roll axis positions and classifies them against a table of
// posture ranges; also forces postures and loads table entries.
//
//   channel   signals                        direction  transfer when
//   input     in_valid/in_ready + 7 fields   in         in_valid && in_ready
//   result    out_valid/out_ready + 3 fields out        out_valid && out_ready
//   config    cfg_valid/cfg_ready, index,    in         cfg_valid && cfg_ready
//             data
//
// A load, an ignored command or an unused code skips the table scan. A
// position set or a posture force scans the first N table entries, N being
// entry_count capped at MAX_ENTRIES, one entry per cycle through the bound
// memories' single read port; a classification scan stops early on a match
// or on an entry whose axis-0 lower bound lies above the axis-0 position.
// One item is in work at a time; the next is taken the cycle after delivery.
// Reset clears positions, posture and configuration; the table is not cleared
// and holds nothing meaningful until loaded. A full output register stalls
// the finished result, not the configuration port, which is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fold_posture_range_classifier_macros.svh"

module fold_posture_range_classifier #(
    parameter int MAX_ENTRIES = 16,
    parameter int MAX_AXES    = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [fprc_pkg::CMD_W-1:0]           command,
    input  logic [fprc_pkg::AXIS_W-1:0]          axis_number,
    input  logic [fprc_pkg::ENTRY_W-1:0]         entry_number,
    input  logic [fprc_pkg::POS_W-1:0]           new_position,
    input  logic [fprc_pkg::POS_W-1:0]           bound_low,
    input  logic [fprc_pkg::POS_W-1:0]           bound_high,
    input  logic [fprc_pkg::POSTURE_W-1:0]       posture_code,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [fprc_pkg::POSTURE_W-1:0]       posture,
    output logic                                 posture_changed,
    output logic                                 ignored,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fprc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fprc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    fprc_pkg::ctrl_cmd_t  ctrl;
    fprc_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    fprc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    fprc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_AXES    (MAX_AXES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .command         (command),
        .axis_number     (axis_number),
        .entry_number    (entry_number),
        .new_position    (new_position),
        .bound_low       (bound_low),
        .bound_high      (bound_high),
        .posture_code    (posture_code),
        .posture         (posture),
        .posture_changed (posture_changed),
        .ignored         (ignored),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ctrl            (ctrl),
        .status          (status)
    );

    // In the cycle after an item is accepted, the block is not ready for another.
    `FPRC_ASSERT_NEXT(a_no_accept_after_accept, in_valid && in_ready, !in_ready)

    // The table scan never overlaps with taking a new item.
    `FPRC_ASSERT(a_scan_blocks_input, ctrl.scan |-> !in_ready)

    // A result appears only when the controller hands one over.
    `FPRC_ASSERT(a_out_from_deliver, $rose(out_valid) |-> $past(ctrl.deliver))

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// Fold posture range classifier testbench
// Drives commands and register writes into the classifier and checks every
// result against a cycle-free model of the axis positions, the posture table
// and the current posture. Random idling on both sides, one long result
// stall, and several register settings from the extremes inward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int CMD_W       = fprc_pkg::CMD_W;
    localparam int AXIS_W      = fprc_pkg::AXIS_W;
    localparam int ENTRY_W     = fprc_pkg::ENTRY_W;
    localparam int POS_W       = fprc_pkg::POS_W;
    localparam int POSTURE_W   = fprc_pkg::POSTURE_W;
    localparam int AXES_CFG_W  = fprc_pkg::AXES_CFG_W;
    localparam int COUNT_CFG_W = fprc_pkg::COUNT_CFG_W;
    localparam int CFG_IDX_W   = fprc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = fprc_pkg::CFG_DATA_W;

    localparam logic [POS_W-1:0] POS_MAX = fprc_pkg::POS_MAX;

    localparam int AXIS_COUNT  = 4;
    localparam int TABLE_DEPTH = 16;
    localparam int ROW_PITCH   = 22000;
    localparam int IDLE_LIMIT  = 2000;
    localparam int LONG_HOLD   = 60;
    localparam int SETTLE      = 20;

    localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
    localparam logic [POS_W-1:0]     POS_ALL_ONES = '1;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [AXIS_W-1:0]    axis_number;
        logic [ENTRY_W-1:0]   entry_number;
        logic [POS_W-1:0]     new_position;
        logic [POS_W-1:0]     bound_low;
        logic [POS_W-1:0]     bound_high;
        logic [POSTURE_W-1:0] posture_code;
    } fold_cmd_t;

    typedef struct packed {
        logic [POSTURE_W-1:0] posture;
        logic                 changed;
        logic                 ignored;
    } posture_report_t;

    // Tracks axis positions, the posture table and the current posture, and
    // holds the reports that the block still owes.
    class posture_tracker;
        logic [AXES_CFG_W-1:0]  axes_cfg;
        logic [COUNT_CFG_W-1:0] count_cfg;
        logic [POS_W-1:0]       axis_pos[AXIS_COUNT];
        logic [POS_W-1:0]       lo_tab[TABLE_DEPTH*AXIS_COUNT];
        logic [POS_W-1:0]       hi_tab[TABLE_DEPTH*AXIS_COUNT];
        logic [POSTURE_W-1:0]   code_tab[TABLE_DEPTH];
        logic [POSTURE_W-1:0]   cur_posture;
        posture_report_t        owed_reports[$];
        int                     errors;

        function new();
            axes_cfg    = '0;
            count_cfg   = '0;
            cur_posture = fprc_pkg::POSTURE_NONE;
            errors      = 0;
            foreach (axis_pos[i]) axis_pos[i] = '0;
            foreach (lo_tab[i])
            begin
                lo_tab[i] = '0;
                hi_tab[i] = '0;
            end
            foreach (code_tab[i]) code_tab[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == fprc_pkg::REG_ACTIVE_AXES)
                axes_cfg = data[AXES_CFG_W-1:0];
            else if (idx == fprc_pkg::REG_ENTRY_COUNT)
                count_cfg = data[COUNT_CFG_W-1:0];
        endfunction

        function int axes_in_use();
            return (axes_cfg > AXIS_COUNT) ? AXIS_COUNT : int'(axes_cfg);
        endfunction

        function int entries_in_use();
            return (count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_cfg);
        endfunction

        // First entry containing every active axis wins; the scan gives up
        // once an axis-0 lower bound lies above the axis-0 position.
        function logic [POSTURE_W-1:0] classify();
            int  na;
            int  ne;
            bit  hit;
            na = axes_in_use();
            ne = entries_in_use();
            if (na == 0)
                return fprc_pkg::POSTURE_NONE;
            for (int e = 0; e < ne; e++)
            begin
                if (lo_tab[e*AXIS_COUNT] > axis_pos[0])
                    break;
                hit = 1'b1;
                for (int a = 0; a < na; a++)
                begin
                    if (lo_tab[e*AXIS_COUNT+a] > axis_pos[a] ||
                        hi_tab[e*AXIS_COUNT+a] < axis_pos[a])
                        hit = 1'b0;
                end
                if (hit)
                    return code_tab[e];
            end
            return fprc_pkg::POSTURE_NONE;
        endfunction

        function void note_command(fold_cmd_t c);
            logic [POS_W-1:0]     pos;
            logic [POS_W:0]       mid;
            logic [POSTURE_W-1:0] found;
            posture_report_t      rep;
            int                   na;
            int                   ne;
            int                   slot;
            na          = axes_in_use();
            ne          = entries_in_use();
            rep.changed = 1'b0;
            rep.ignored = 1'b0;
            pos = (c.new_position > POS_MAX) ? POS_MAX : c.new_position;
            case (c.command)
                fprc_pkg::CMD_SET_POSITION:
                begin
                    if (c.axis_number >= na || axis_pos[c.axis_number] == pos)
                        rep.ignored = 1'b1;
                    else
                    begin
                        axis_pos[c.axis_number] = pos;
                        found = classify();
                        if (found != cur_posture)
                        begin
                            cur_posture = found;
                            rep.changed = 1'b1;
                        end
                    end
                end
                fprc_pkg::CMD_FORCE_POSTURE:
                begin
                    if (c.posture_code == cur_posture)
                        rep.ignored = 1'b1;
                    else
                    begin
                        cur_posture = c.posture_code;
                        rep.changed = 1'b1;
                        // Every matching entry moves the axes; the last one sticks.
                        for (int e = 0; e < ne; e++)
                        begin
                            if (code_tab[e] == c.posture_code)
                            begin
                                for (int a = 0; a < na; a++)
                                begin
                                    slot = e*AXIS_COUNT + a;
                                    mid  = ({1'b0, lo_tab[slot]} + hi_tab[slot]) >> 1;
                                    axis_pos[a] = (mid > POS_MAX) ? POS_MAX : mid[POS_W-1:0];
                                end
                            end
                        end
                    end
                end
                fprc_pkg::CMD_LOAD_ENTRY:
                begin
                    slot         = c.entry_number*AXIS_COUNT + c.axis_number;
                    lo_tab[slot] = c.bound_low;
                    hi_tab[slot] = c.bound_high;
                    code_tab[c.entry_number] = c.posture_code;
                end
                default:
                    rep.ignored = 1'b1;
            endcase
            rep.posture = cur_posture;
            owed_reports.insert(owed_reports.size(), rep);
        endfunction

        function void check_outcome(posture_report_t got);
            posture_report_t want;
            if (owed_reports.size() == 0)
            begin
                $display("%0t: unexpected result posture %0d changed %0b ignored %0b",
                         $time, got.posture, got.changed, got.ignored);
                errors++;
                return;
            end
            want = owed_reports.pop_front();
            if (got.posture !== want.posture)
            begin
                $display("%0t: posture expected %0d actual %0d",
                         $time, want.posture, got.posture);
                errors++;
            end
            if (got.changed !== want.changed)
            begin
                $display("%0t: posture_changed expected %0b actual %0b",
                         $time, want.changed, got.changed);
                errors++;
            end
            if (got.ignored !== want.ignored)
            begin
                $display("%0t: ignored expected %0b actual %0b",
                         $time, want.ignored, got.ignored);
                errors++;
            end
        endfunction

        function int pending();
            return owed_reports.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n           = 1'b0;
    logic                   in_valid        = 1'b0;
    logic                   in_ready;
    logic [CMD_W-1:0]       command         = '0;
    logic [AXIS_W-1:0]      axis_number     = '0;
    logic [ENTRY_W-1:0]     entry_number    = '0;
    logic [POS_W-1:0]       new_position    = '0;
    logic [POS_W-1:0]       bound_low       = '0;
    logic [POS_W-1:0]       bound_high      = '0;
    logic [POSTURE_W-1:0]   posture_code    = '0;
    logic                   out_valid;
    logic                   out_ready       = 1'b0;
    logic [POSTURE_W-1:0]   posture;
    logic                   posture_changed;
    logic                   ignored;
    logic                   cfg_valid       = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index       = '0;
    logic [CFG_DATA_W-1:0]  cfg_data        = '0;

    posture_tracker tracker = new();
    bit             idling        = 1'b1;
    bit             long_hold_due = 1'b0;
    int             quiet_cycles  = 0;
    int             aim_entry     = 0;

    fold_posture_range_classifier dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic fold_cmd_t mk(logic [CMD_W-1:0] cmd, int axis, int entry,
                                     logic [POS_W-1:0] pos, logic [POS_W-1:0] lo,
                                     logic [POS_W-1:0] hi, int code);
        fold_cmd_t c;
        c.command      = cmd;
        c.axis_number  = axis[AXIS_W-1:0];
        c.entry_number = entry[ENTRY_W-1:0];
        c.new_position = pos;
        c.bound_low    = lo;
        c.bound_high   = hi;
        c.posture_code = code[POSTURE_W-1:0];
        return c;
    endfunction

    // Axis-0 lower bounds climb with the entry number so the table stays sorted.
    function automatic void make_bounds(int e, int a, output logic [POS_W-1:0] lo,
                                        output logic [POS_W-1:0] hi);
        int l;
        int h;
        if (a == 0)
        begin
            l = e*ROW_PITCH + $urandom_range(0, 2000);
            h = l + $urandom_range(0, 60000);
        end
        else
        begin
            l = $urandom_range(0, 280000);
            h = l + $urandom_range(0, 80000);
        end
        lo = l[POS_W-1:0];
        hi = (h > POS_MAX) ? POS_MAX : h[POS_W-1:0];
    endfunction

    function automatic fold_cmd_t random_command();
        fold_cmd_t        c;
        int               roll;
        int               pick;
        int               na;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        c.axis_number  = AXIS_W'($urandom);
        c.entry_number = ENTRY_W'($urandom);
        c.new_position = POS_W'($urandom_range(0, POS_ALL_ONES));
        c.bound_low    = POS_W'($urandom_range(0, POS_ALL_ONES));
        c.bound_high   = POS_W'($urandom_range(0, POS_ALL_ONES));
        c.posture_code = POSTURE_W'($urandom);
        na   = tracker.axes_in_use();
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0)
            aim_entry = $urandom_range(0, TABLE_DEPTH-1);
        if (roll < 50)
        begin
            c.command = fprc_pkg::CMD_SET_POSITION;
            if (na > 0 && $urandom_range(0, 99) < 85)
                c.axis_number = AXIS_W'($urandom_range(0, na-1));
            pick = $urandom_range(0, 99);
            lo   = tracker.lo_tab[aim_entry*AXIS_COUNT + c.axis_number];
            hi   = tracker.hi_tab[aim_entry*AXIS_COUNT + c.axis_number];
            if (pick < 70)
                c.new_position = (lo <= hi) ? POS_W'($urandom_range(lo, hi)) : lo;
            else if (pick < 80)
                c.new_position = tracker.axis_pos[c.axis_number];
            else if (pick >= 90)
                case ($urandom_range(0, 2))
                    0:       c.new_position = '0;
                    1:       c.new_position = POS_MAX;
                    default: c.new_position = POS_ALL_ONES;
                endcase
        end
        else if (roll < 65)
        begin
            c.command = fprc_pkg::CMD_FORCE_POSTURE;
            if ($urandom_range(0, 99) < 60)
                c.posture_code = tracker.code_tab[$urandom_range(0, TABLE_DEPTH-1)];
        end
        else if (roll < 95)
        begin
            c.command = fprc_pkg::CMD_LOAD_ENTRY;
            if ($urandom_range(0, 99) < 80)
            begin
                make_bounds(c.entry_number, c.axis_number, lo, hi);
                c.bound_low  = lo;
                c.bound_high = hi;
            end
        end
        else
            c.command = CMD_UNUSED;
        return c;
    endfunction

    // Valid stays up from one transfer into the next unless an idle burst falls between.
    task automatic send(input fold_cmd_t c);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= c.command;
        axis_number  <= c.axis_number;
        entry_number <= c.entry_number;
        new_position <= c.new_position;
        bound_low    <= c.bound_low;
        bound_high   <= c.bound_high;
        posture_code <= c.posture_code;
        do @(posedge clk); while (in_ready !== 1'b1);
        tracker.note_command(c);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        tracker.write_reg(idx, data);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] axes,
                             input logic [CFG_DATA_W-1:0] count, input bit touch_unused);
        drain_results();
        write_reg(fprc_pkg::REG_ACTIVE_AXES, axes);
        write_reg(fprc_pkg::REG_ENTRY_COUNT, count);
        if (touch_unused)
            write_reg(REG_UNUSED, 5'd31);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] axes,
                             input logic [CFG_DATA_W-1:0] count, input int n_items,
                             input bit with_hold, input bit touch_unused, input bit quiet);
        configure(axes, count, touch_unused);
        idling = !quiet;
        for (int i = 0; i < n_items; i++)
        begin
            if (with_hold && i == 10)
                long_hold_due = 1'b1;
            send(random_command());
        end
    endtask

    // Result side: checks each transfer, then picks the next ready level.
    initial
    begin
        posture_report_t seen;
        int              hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
            begin
                seen.posture = posture;
                seen.changed = posture_changed;
                seen.ignored = ignored;
                tracker.check_outcome(seen);
            end
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                hold_left = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        logic [POS_W-1:0]     lo;
        logic [POS_W-1:0]     hi;
        int                   code;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No table entries in use: saturation, unchanged sets, forces with no match.
        configure(5'd4, 5'd0, 1'b0);
        send(mk(fprc_pkg::CMD_SET_POSITION, 0, 0, '0, '0, '0, 0));
        send(mk(fprc_pkg::CMD_SET_POSITION, 0, 0, POS_ALL_ONES, '0, '0, 0));
        send(mk(fprc_pkg::CMD_SET_POSITION, 0, 0, POS_MAX, '0, '0, 0));
        send(mk(fprc_pkg::CMD_SET_POSITION, 1, 0, 19'd12345, '0, '0, 0));
        send(mk(fprc_pkg::CMD_FORCE_POSTURE, 0, 0, '0, '0, '0, fprc_pkg::POSTURE_NONE));
        send(mk(fprc_pkg::CMD_FORCE_POSTURE, 0, 0, '0, '0, '0, 7));
        send(mk(CMD_UNUSED, 3, 15, POS_ALL_ONES, POS_ALL_ONES, POS_ALL_ONES, 7));
        for (int a = 0; a < AXIS_COUNT; a++)
            send(mk(fprc_pkg::CMD_LOAD_ENTRY, a, 0, '0, '0, POS_ALL_ONES, 5));
        // Entry 1 never matches on axis 0 and saturates its midpoint on axis 2.
        send(mk(fprc_pkg::CMD_LOAD_ENTRY, 0, 1, '0, 19'd300000, 19'd100000, 2));
        send(mk(fprc_pkg::CMD_LOAD_ENTRY, 1, 1, '0, '0, '0, 2));
        send(mk(fprc_pkg::CMD_LOAD_ENTRY, 2, 1, '0, POS_ALL_ONES, POS_ALL_ONES, 2));
        send(mk(fprc_pkg::CMD_LOAD_ENTRY, 3, 1, '0, 19'd1000, 19'd3000, 2));
        send(mk(fprc_pkg::CMD_LOAD_ENTRY, 3, 15, '0, 19'd7, 19'd9, 7));

        configure(5'd3, 5'd2, 1'b0);
        send(mk(fprc_pkg::CMD_SET_POSITION, 3, 0, 19'd5, '0, '0, 0));
        send(mk(fprc_pkg::CMD_SET_POSITION, 0, 0, 19'd100, '0, '0, 0));
        send(mk(fprc_pkg::CMD_FORCE_POSTURE, 0, 0, '0, '0, '0, 2));
        send(mk(fprc_pkg::CMD_FORCE_POSTURE, 0, 0, '0, '0, '0, 2));
        send(mk(fprc_pkg::CMD_FORCE_POSTURE, 0, 0, '0, '0, '0, 6));
        send(mk(fprc_pkg::CMD_SET_POSITION, 1, 0, 19'd1, '0, '0, 0));

        // Fill the whole table, sorted on axis 0, before any wider entry count.
        for (int e = 0; e < TABLE_DEPTH; e++)
        begin
            code = $urandom_range(1, 7);
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                make_bounds(e, a, lo, hi);
                send(mk(fprc_pkg::CMD_LOAD_ENTRY, a, e,
                        POS_W'($urandom_range(0, POS_ALL_ONES)), lo, hi, code));
            end
        end

        run_phase(5'd4,  5'd16, 70, 1'b1, 1'b0, 1'b0);
        run_phase(5'd1,  5'd6,  60, 1'b0, 1'b0, 1'b0);
        run_phase(5'd0,  5'd16, 50, 1'b0, 1'b0, 1'b0);
        run_phase(5'd7,  5'd31, 60, 1'b0, 1'b1, 1'b0);
        run_phase(5'd28, 5'd20, 60, 1'b0, 1'b0, 1'b0);
        run_phase(5'd2,  5'd0,  50, 1'b0, 1'b0, 1'b0);
        run_phase(5'd3,  5'd17, 60, 1'b0, 1'b0, 1'b0);
        run_phase(5'd4,  5'd16, 70, 1'b0, 1'b0, 1'b1);

        drain_results();
        if (tracker.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
